@@ rtl/ils_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ils_pkg;

   // item field widths
   localparam int OP_W    = 3;
   localparam int POS_W   = 16;
   localparam int VAL_W   = 32;
   localparam int ST_W    = 2;
   localparam int CNT_W   = 5;

   // default store depth
   localparam int DEPTH_DEFAULT = 16;

   // operation codes
   localparam logic [OP_W-1:0] OP_READ     = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
   localparam logic [OP_W-1:0] OP_INS_POS  = 3'd3;
   localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

   // result status codes
   localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   // what the decoded item asks the controller to do
   typedef enum logic [1:0] {
      ACT_READ,
      ACT_INSERT,
      ACT_DELETE,
      ACT_REJECT
   } action_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture the request fields
      logic decide;      // latch decode results, set up the move pointer
      logic rd_shift;    // read the neighbor of the move pointer
      logic shift_write; // write the neighbor into the pointer slot, step pointer
      logic write_new;   // write the new value at the insert position
      logic count_inc;
      logic count_dec;
      logic finish;      // load the result registers and strobe them
      logic use_rdata;   // result value comes from the memory read
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      action_type action;
      logic       shift_more;
      logic       insert_mode;
   } stat_type;

endpackage
`default_nettype wire

@@ rtl/indexed_list_store.sv @@
// indexed_list_store: ordered list of up to DEPTH signed 32-bit values,
// addressed by position (0 is the head), held in a single-port-write RAM.
// Request channel: drive req_op, req_index_pos and req_item_value with start
// high; the item is taken at a clock edge where start is high and busy low.
// busy stays high until the item's work is done.
// Result channel: one result per item, on rsp_read_value, rsp_status and
// rsp_count for exactly one cycle with rsp_valid high. There is no
// back-pressure; the receiver must take it in that cycle. A new item may be
// started in the cycle its predecessor's result is shown.
// Work per item, n entries, position p: a rejected item ends in decode, a read
// waits on the RAM read, an insert moves the n-p entries from p on, and a delete
// moves the n-1-p entries above p.
// Each entry moves in three steps (check, RAM read, RAM write) through the
// one RAM read port, so the item rate is set by that move loop.
// Reset (synchronous, active high) empties the list at once; no clearing
// pass is needed since only positions below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module indexed_list_store #(
   parameter int DEPTH = ils_pkg::DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic        [ils_pkg::OP_W-1:0]   req_op,
   input  wire logic signed [ils_pkg::POS_W-1:0]  req_index_pos,
   input  wire logic signed [ils_pkg::VAL_W-1:0]  req_item_value,
   output logic                                   rsp_valid,
   output logic signed      [ils_pkg::VAL_W-1:0]  rsp_read_value,
   output logic             [ils_pkg::ST_W-1:0]   rsp_status,
   output logic             [ils_pkg::CNT_W-1:0]  rsp_count
);

   ils_pkg::cmd_type  cmd;
   ils_pkg::stat_type stat;

   ils_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ils_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req_op),
      .req_index_pos  (req_index_pos),
      .req_item_value (req_item_value),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

endmodule
`default_nettype wire

@@ rtl/ils_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ils_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/ils_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ils_datapath #(
   parameter int DEPTH = ils_pkg::DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic        [ils_pkg::OP_W-1:0]   req_op,
   input  wire logic signed [ils_pkg::POS_W-1:0]  req_index_pos,
   input  wire logic signed [ils_pkg::VAL_W-1:0]  req_item_value,
   input  wire ils_pkg::cmd_type                  cmd,
   output ils_pkg::stat_type                      stat,
   output logic                                   rsp_valid,
   output logic signed      [ils_pkg::VAL_W-1:0]  rsp_read_value,
   output logic             [ils_pkg::ST_W-1:0]   rsp_status,
   output logic             [ils_pkg::CNT_W-1:0]  rsp_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // captured request
   logic [ils_pkg::OP_W-1:0]  op_ff;
   logic [ils_pkg::POS_W-1:0] pos_ff;
   logic [ils_pkg::VAL_W-1:0] val_ff;

   // list state and move bookkeeping
   logic [CW-1:0]             count_ff, count_in;
   logic [AW-1:0]             ptr_ff, ptr_in;
   logic [AW-1:0]             tgt_ff;
   logic                      ins_ff;
   logic [ils_pkg::ST_W-1:0]  code_ff;
   logic [ils_pkg::VAL_W-1:0] rv_ff;

   // result registers
   logic                      rsp_valid_ff;
   logic [ils_pkg::VAL_W-1:0] rsp_value_ff;
   logic [ils_pkg::ST_W-1:0]  rsp_status_ff;
   logic [ils_pkg::CNT_W-1:0] rsp_count_ff;

   // decode signals
   logic [ils_pkg::POS_W-1:0] count_ext;
   logic [ils_pkg::POS_W-1:0] ins_pos;
   logic                      pos_neg;
   logic                      pos_in;
   logic                      full;
   ils_pkg::action_type       action;
   logic [ils_pkg::ST_W-1:0]  code_dec;
   logic [ils_pkg::VAL_W-1:0] rv_dec;
   logic [CW:0]               ptr_plus_ext;
   logic [CW+ils_pkg::CNT_W-1:0] count_wide;

   // memory ports
   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   logic [ils_pkg::VAL_W-1:0] ram_wdata;
   logic [AW-1:0]             ram_raddr;
   logic [ils_pkg::VAL_W-1:0] ram_rdata;

   // position checks against the current count
   assign count_ext = ils_pkg::POS_W'(count_ff);
   assign pos_neg   = pos_ff[ils_pkg::POS_W-1];
   assign pos_in    = !pos_neg && (pos_ff < count_ext);
   assign full      = (count_ff == CW'(DEPTH));

   // effective insert position; a negative position means the head
   always_comb begin
      case (op_ff)
         ils_pkg::OP_INS_HEAD: ins_pos = '0;
         ils_pkg::OP_INS_TAIL: ins_pos = count_ext;
         default:              ins_pos = pos_neg ? '0 : pos_ff;
      endcase
   end

   // operation decode
   always_comb begin
      action   = ils_pkg::ACT_REJECT;
      code_dec = ils_pkg::ST_RANGE;
      rv_dec   = '0;
      case (op_ff)
         ils_pkg::OP_READ: begin
            if (pos_in) begin
               action   = ils_pkg::ACT_READ;
               code_dec = ils_pkg::ST_DONE;
            end else begin
               rv_dec = '1;
            end
         end
         ils_pkg::OP_INS_HEAD, ils_pkg::OP_INS_TAIL, ils_pkg::OP_INS_POS: begin
            // position check ahead of the full check
            if (ins_pos > count_ext) begin
               code_dec = ils_pkg::ST_RANGE;
            end else if (full) begin
               code_dec = ils_pkg::ST_FULL;
            end else begin
               action   = ils_pkg::ACT_INSERT;
               code_dec = ils_pkg::ST_DONE;
            end
         end
         ils_pkg::OP_DELETE: begin
            if (pos_in) begin
               action   = ils_pkg::ACT_DELETE;
               code_dec = ils_pkg::ST_DONE;
            end
         end
         default: begin
            action   = ils_pkg::ACT_REJECT;
            code_dec = ils_pkg::ST_RANGE;
         end
      endcase
   end

   // move loop end: insert shifts down to the target, delete up to the tail
   assign ptr_plus_ext     = (CW+1)'(ptr_ff) + (CW+1)'(1);
   assign stat.action      = action;
   assign stat.insert_mode = ins_ff;
   assign stat.shift_more  = ins_ff ? (ptr_ff > tgt_ff)
                                    : (ptr_plus_ext < (CW+1)'(count_ff));

   // memory addressing
   assign ram_raddr = cmd.rd_shift ? (ins_ff ? ptr_ff - AW'(1) : ptr_ff + AW'(1))
                                   : pos_ff[AW-1:0];
   assign ram_we    = cmd.shift_write || cmd.write_new;
   assign ram_waddr = cmd.write_new ? tgt_ff : ptr_ff;
   assign ram_wdata = cmd.write_new ? val_ff : ram_rdata;

   ils_ram #(
      .WIDTH (ils_pkg::VAL_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // next count and pointer
   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.decide) begin
         ptr_in = (action == ils_pkg::ACT_INSERT) ? count_ff[AW-1:0] : pos_ff[AW-1:0];
      end else if (cmd.shift_write) begin
         ptr_in = ins_ff ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
      end
   end

   // count field carries the count modulo 32
   assign count_wide = (CW+ils_pkg::CNT_W)'(count_in);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         pos_ff <= $unsigned(req_index_pos);
         val_ff <= $unsigned(req_item_value);
      end
      ptr_ff <= ptr_in;
      if (cmd.decide) begin
         tgt_ff  <= ins_pos[AW-1:0];
         ins_ff  <= (action == ils_pkg::ACT_INSERT);
         code_ff <= code_dec;
         rv_ff   <= rv_dec;
      end
      if (cmd.finish) begin
         if (cmd.use_rdata) begin
            rsp_value_ff <= ram_rdata;
         end else if (cmd.decide) begin
            rsp_value_ff <= rv_dec;
         end else begin
            rsp_value_ff <= rv_ff;
         end
         rsp_status_ff <= cmd.decide ? code_dec : code_ff;
         rsp_count_ff  <= count_wide[ils_pkg::CNT_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = $signed(rsp_value_ff);
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;

endmodule
`default_nettype wire

@@ rtl/ils_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ils_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire ils_pkg::stat_type stat,
   output ils_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ_WAIT,
      S_MOVE_CHK,
      S_MOVE_RD,
      S_MOVE_WR,
      S_PUT_NEW
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decide = 1'b1;
            case (stat.action)
               ils_pkg::ACT_READ:   state_in = S_READ_WAIT;
               ils_pkg::ACT_INSERT: state_in = S_MOVE_CHK;
               ils_pkg::ACT_DELETE: state_in = S_MOVE_CHK;
               default: begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            endcase
         end
         S_READ_WAIT: begin
            cmd.finish    = 1'b1;
            cmd.use_rdata = 1'b1;
            state_in      = S_IDLE;
         end
         S_MOVE_CHK: begin
            if (stat.shift_more) begin
               state_in = S_MOVE_RD;
            end else if (stat.insert_mode) begin
               state_in = S_PUT_NEW;
            end else begin
               cmd.count_dec = 1'b1;
               cmd.finish    = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_MOVE_RD: begin
            cmd.rd_shift = 1'b1;
            state_in     = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            cmd.shift_write = 1'b1;
            state_in        = S_MOVE_CHK;
         end
         S_PUT_NEW: begin
            cmd.write_new = 1'b1;
            cmd.count_inc = 1'b1;
            cmd.finish    = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy_in = (state_in != S_IDLE);

   // state and registered busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import ils_pkg::*;

   localparam int LIST_DEPTH = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1600;
   // longest item: insert at the head of a list one short of full, plus margin
   localparam int DRAIN_CYCLES = 3 * LIST_DEPTH + 16;
   localparam int SETTLE_LIMIT = 100000;
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFFFFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 16'sh8000;
   localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7FFF;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic        [ST_W-1:0]  status;
      logic        [CNT_W-1:0] count;
   } list_result_t;

   // one directed row; pinned rows carry a hand-written result
   typedef struct packed {
      logic        [OP_W-1:0]  op;
      logic signed [POS_W-1:0] pos;
      logic signed [VAL_W-1:0] val;
      logic        [4:0]       reps;
      logic                    rand_val;
      logic                    pinned;
      logic signed [VAL_W-1:0] rv;
      logic        [ST_W-1:0]  st;
      logic        [CNT_W-1:0] cnt;
   } stim_row_t;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic        [OP_W-1:0]  req_op;
   logic signed [POS_W-1:0] req_index_pos;
   logic signed [VAL_W-1:0] req_item_value;
   logic                    rsp_valid;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic        [ST_W-1:0]  rsp_status;
   logic        [CNT_W-1:0] rsp_count;

   // hand-written result that rides along with the current item
   logic                    pin_on;
   logic signed [VAL_W-1:0] pin_rv;
   logic        [ST_W-1:0]  pin_st;
   logic        [CNT_W-1:0] pin_cnt;

   // shadow copy of the list
   logic signed [VAL_W-1:0] list_vals [LIST_DEPTH];
   int                      list_len = 0;

   list_result_t pending_results [$];
   int           items_taken = 0;
   int           err_count = 0;
   bit           idle_enabled = 1'b1;

   stim_row_t directed_rows [25] = '{
      '{OP_READ,     16'sd0,     32'sd0,  5'd1,  1'b0, 1'b1, -32'sd1, ST_RANGE, 5'd0},
      '{OP_DELETE,   16'sd0,     32'sd0,  5'd1,  1'b0, 1'b1, 32'sd0,  ST_RANGE, 5'd0},
      '{OP_INS_POS,  16'sd1,     32'sd5,  5'd1,  1'b0, 1'b1, 32'sd0,  ST_RANGE, 5'd0},
      '{OP_INS_HEAD, 16'sd0,     VAL_MIN, 5'd1,  1'b0, 1'b1, 32'sd0,  ST_DONE,  5'd1},
      '{OP_INS_TAIL, 16'sd0,     VAL_MAX, 5'd1,  1'b0, 1'b1, 32'sd0,  ST_DONE,  5'd2},
      '{OP_INS_POS,  POS_MIN,    32'sd0,  5'd1,  1'b0, 1'b1, 32'sd0,  ST_DONE,  5'd3},
      '{OP_READ,     16'sd1,     32'sd0,  5'd1,  1'b0, 1'b1, VAL_MIN, ST_DONE,  5'd3},
      '{OP_READ,     16'sd2,     32'sd0,  5'd1,  1'b0, 1'b0, 32'sd0,  ST_DONE,  5'd0},
      '{OP_READ,     16'sd3,     32'sd0,  5'd1,  1'b0, 1'b1, -32'sd1, ST_RANGE, 5'd3},
      '{OP_READ,     -16'sd1,    32'sd0,  5'd1,  1'b0, 1'b1, -32'sd1, ST_RANGE, 5'd3},
      '{OP_READ,     POS_MAX,    32'sd0,  5'd1,  1'b0, 1'b1, -32'sd1, ST_RANGE, 5'd3},
      '{OP_SPARE_LAST, POS_MAX,  VAL_MAX, 5'd1,  1'b0, 1'b1, 32'sd0,  ST_RANGE, 5'd3},
      '{OP_INS_POS,  16'sd3,     -32'sd1, 5'd1,  1'b0, 1'b0, 32'sd0,  ST_DONE,  5'd0},
      '{OP_DELETE,   POS_MAX,    32'sd0,  5'd1,  1'b0, 1'b1, 32'sd0,  ST_RANGE, 5'd4},
      '{OP_DELETE,   POS_MIN,    32'sd0,  5'd1,  1'b0, 1'b1, 32'sd0,  ST_RANGE, 5'd4},
      '{OP_DELETE,   16'sd1,     32'sd0,  5'd1,  1'b0, 1'b0, 32'sd0,  ST_DONE,  5'd0},
      // fill up to the top
      '{OP_INS_TAIL, 16'sd0,     32'sd0,  5'd13, 1'b1, 1'b0, 32'sd0,  ST_DONE,  5'd0},
      '{OP_INS_HEAD, 16'sd0,     32'sd9,  5'd1,  1'b0, 1'b1, 32'sd0,  ST_FULL,  5'd16},
      '{OP_INS_POS,  16'sd17,    32'sd9,  5'd1,  1'b0, 1'b1, 32'sd0,  ST_RANGE, 5'd16},
      '{OP_INS_POS,  16'sd16,    32'sd9,  5'd1,  1'b0, 1'b1, 32'sd0,  ST_FULL,  5'd16},
      '{OP_INS_POS,  -16'sd5,    32'sd9,  5'd1,  1'b0, 1'b1, 32'sd0,  ST_FULL,  5'd16},
      '{OP_READ,     16'sd15,    32'sd0,  5'd1,  1'b0, 1'b0, 32'sd0,  ST_DONE,  5'd0},
      '{OP_DELETE,   16'sd0,     32'sd0,  5'd1,  1'b0, 1'b0, 32'sd0,  ST_DONE,  5'd0},
      '{OP_DELETE,   16'sd15,    32'sd0,  5'd1,  1'b0, 1'b1, 32'sd0,  ST_RANGE, 5'd15},
      '{OP_READ,     16'sd14,    32'sd0,  5'd1,  1'b0, 1'b0, 32'sd0,  ST_DONE,  5'd0}
   };

   indexed_list_store dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_index_pos  (req_index_pos),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #16000000;
      $display("FAILURE");
      $finish;
   end

   // shift the tail down one place and place the new value, unless full
   function automatic logic [ST_W-1:0] insert_value(input int p, input logic signed [VAL_W-1:0] v);
      int i;
      if (list_len >= LIST_DEPTH) return ST_FULL;
      for (i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
      list_vals[p] = v;
      list_len++;
      return ST_DONE;
   endfunction

   // apply one operation to the shadow list and return its result
   function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                  input logic signed [POS_W-1:0] pos,
                                                  input logic signed [VAL_W-1:0] val);
      list_result_t res;
      int p;
      int i;
      res.read_value = '0;
      res.status = ST_DONE;
      p = pos;
      case (op)
         OP_READ: begin
            if (p < 0 || p >= list_len) begin
               res.read_value = -32'sd1;
               res.status = ST_RANGE;
            end else begin
               res.read_value = list_vals[p];
            end
         end
         OP_INS_HEAD: res.status = insert_value(0, val);
         OP_INS_TAIL: res.status = insert_value(list_len, val);
         OP_INS_POS: begin
            if (p < 0) p = 0;
            if (p > list_len) res.status = ST_RANGE;
            else res.status = insert_value(p, val);
         end
         OP_DELETE: begin
            if (p < 0 || p >= list_len) begin
               res.status = ST_RANGE;
            end else begin
               for (i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
               list_len--;
            end
         end
         default: res.status = ST_RANGE;
      endcase
      res.count = CNT_W'(list_len);
      return res;
   endfunction

   // result check first (it belongs to an earlier item), then item capture
   always @(posedge clock) begin
      list_result_t want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $error("result with no item outstanding");
               err_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d", want.read_value, rsp_read_value);
                  err_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  err_count++;
               end
               if (rsp_count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_count);
                  err_count++;
               end
            end
         end
         if (start && !busy) begin
            want = apply_list_op(req_op, req_index_pos, req_item_value);
            if (pin_on) begin
               want.read_value = pin_rv;
               want.status = pin_st;
               want.count = pin_cnt;
            end
            pending_results.push_back(want);
            items_taken++;
         end
      end
   end

   // present one item from a falling edge and hold it until taken
   task automatic issue_item(input logic [OP_W-1:0] op, input logic signed [POS_W-1:0] pos,
                             input logic signed [VAL_W-1:0] val, input stim_row_t row);
      int taken_before;
      while (idle_enabled && $urandom_range(0, 99) < 23) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_index_pos <= pos;
      req_item_value <= val;
      pin_on <= row.pinned;
      pin_rv <= row.rv;
      pin_st <= row.st;
      pin_cnt <= row.cnt;
      taken_before = items_taken;
      do @(negedge clock); while (items_taken == taken_before);
   endtask

   // position mostly near the list, sometimes just past it, just below zero or anywhere at all
   function automatic logic signed [POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return POS_W'($urandom_range(0, list_len));
      if (r < 85) return POS_W'(list_len + $urandom_range(1, 2));
      if (r < 92) return -POS_W'($urandom_range(1, 3));
      return POS_W'($urandom);
   endfunction

   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2: return '0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      stim_row_t row;
      stim_row_t free_row;
      logic [OP_W-1:0] op;
      logic signed [VAL_W-1:0] val;
      bit fill_phase;
      int n;
      int k;
      int r;
      int waited;

      reset = 1'b1;
      start = 1'b0;
      req_op = OP_READ;
      req_index_pos = '0;
      req_item_value = '0;
      pin_on = 1'b0;
      pin_rv = '0;
      pin_st = ST_DONE;
      pin_cnt = '0;
      free_row = '0;
      fill_phase = 1'b1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (n = 0; n < $size(directed_rows); n++) begin
         row = directed_rows[n];
         for (k = 0; k < row.reps; k++) begin
            val = row.rand_val ? pick_value() : row.val;
            issue_item(row.op, row.pos, val, row);
         end
      end

      // random items, swinging between filling and draining the list
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         idle_enabled = !(n >= 500 && n < 850);
         if ($urandom_range(0, 59) == 0) fill_phase = !fill_phase;
         if (fill_phase && list_len == LIST_DEPTH && $urandom_range(0, 7) == 0) fill_phase = 1'b0;
         if (!fill_phase && list_len == 0 && $urandom_range(0, 7) == 0) fill_phase = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 4) op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         else if (r < 24) op = OP_READ;
         else if (r < (fill_phase ? 84 : 44)) begin
            case ($urandom_range(0, 2))
               0: op = OP_INS_HEAD;
               1: op = OP_INS_TAIL;
               default: op = OP_INS_POS;
            endcase
         end else op = OP_DELETE;
         issue_item(op, pick_position(), pick_value(), free_row);
      end
      start <= 1'b0;

      // let the last results come out
      waited = 0;
      while (pending_results.size() != 0 && waited < SETTLE_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/ils_pkg.sv
rtl/ils_ram.sv
rtl/ils_datapath.sv
rtl/ils_ctrl.sv
rtl/indexed_list_store.sv
sim/testbench.sv
